/* hdl/assert_macros.svh */
// Assertion helpers. Each expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/scp_pkg.sv */
package scp_pkg;

  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int POS_BITS   = 32;
  localparam int CASE_BITS  = 2;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PSUM_W = COORD_BITS + 2;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int MAG_W  = NUM_W;
  localparam int D2_W   = MAG_W + 1;
  localparam int REM_W  = D2_W + 1;
  localparam int X_W    = MAG_W + FRAC_BITS + 2;
  localparam int XP_W   = X_W + POS_BITS;
  localparam int STEPS  = POS_BITS;
  localparam int LANES  = 2;

  localparam int SKID_DEPTH = 2;
  localparam int SKID_AW    = $clog2(SKID_DEPTH);
  localparam int SKID_CW    = $clog2(SKID_DEPTH + 1);

  localparam logic signed [POS_BITS-1:0] POS_HALF      = POS_BITS'(1) << (FRAC_BITS - 1);
  localparam logic signed [POS_BITS-1:0] POS_MINUS_ONE = -(POS_BITS'(1) << FRAC_BITS);
  localparam logic [POS_BITS-1:0] POS_MAX_MAG = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic [POS_BITS-1:0] POS_MIN_MAG = {1'b1, {(POS_BITS-1){1'b0}}};

  typedef enum logic [CASE_BITS-1:0] {
    CASE_PROPER   = 2'd0,
    CASE_PARALLEL = 2'd1,
    CASE_DEGEN    = 2'd2
  } solve_case_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PSUM_W-1:0]     psum_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [NUM_W-1:0]      num_t;

  typedef struct packed {
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_end_x;
    coord_t second_end_y;
  } seg_pair_t;

  // One quotient to be formed: sign and magnitudes of numerator and divisor.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] num;
    logic [MAG_W-1:0] den;
  } div_arg_t;

  typedef struct packed {
    logic                      valid;
    solve_case_t               scase;
    div_arg_t [LANES-1:0]      arg;
  } div_req_t;

  typedef struct packed {
    logic [X_W-1:0]  x;
    logic [D2_W-1:0] d2;
    logic            neg;
  } prep_lane_t;

  typedef struct packed {
    logic                   valid;
    solve_case_t            scase;
    prep_lane_t [LANES-1:0] lane;
  } prep_t;

  // sh holds the dividend bits still to come; quotient bits enter at the bottom.
  typedef struct packed {
    logic [D2_W-1:0]     rem;
    logic [POS_BITS-1:0] sh;
    logic [D2_W-1:0]     d2;
    logic                neg;
    logic                ovf;
  } lane_st_t;

  typedef struct packed {
    logic                 valid;
    solve_case_t          scase;
    lane_st_t [LANES-1:0] lane;
  } div_stage_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] pos_on_first;
    logic signed [POS_BITS-1:0] pos_on_second;
    solve_case_t                solve_case;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } res_word_t;

endpackage

/* hdl/scp_ifs.sv */
interface scp_in_if;
  import scp_pkg::*;

  logic   valid;
  logic   ready;
  coord_t first_start_x;
  coord_t first_start_y;
  coord_t first_end_x;
  coord_t first_end_y;
  coord_t second_start_x;
  coord_t second_start_y;
  coord_t second_end_x;
  coord_t second_end_y;

  modport source (
    output valid,
    output first_start_x, first_start_y, first_end_x, first_end_y,
    output second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );

  modport sink (
    input  valid,
    input  first_start_x, first_start_y, first_end_x, first_end_y,
    input  second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface

interface scp_out_if;
  import scp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [POS_BITS-1:0] pos_on_first;
  logic signed [POS_BITS-1:0] pos_on_second;
  logic [CASE_BITS-1:0]       solve_case;

  modport source (
    output valid,
    output pos_on_first, pos_on_second, solve_case,
    input  ready
  );

  modport sink (
    input  valid,
    input  pos_on_first, pos_on_second, solve_case,
    output ready
  );
endinterface

/* hdl/segment_crossing_parameters_core.sv */
// Channel  Dir  Handshake    Word
// in_ch    in   valid/ready  two segments, eight signed 24-bit coordinates
// out_ch   out  valid/ready  pos_on_first, pos_on_second (Q16.16), solve_case
//
// One word accepted and one delivered per cycle when out_ch keeps up.
// Pipeline: four front stages (differences, products, cross terms,
// case select), two divider set-up stages and 32 restoring-division stages,
// one quotient bit each, then the output buffer register.
// rst_n (synchronous) clears the valid bits and the output buffer.
// The whole pipeline holds while the output buffer is full; in_ch.ready is low then.
module segment_crossing_parameters_core (
  input  logic       clk,
  input  logic       rst_n,
  scp_in_if.sink     in_ch,
  scp_out_if.source  out_ch
);
  import scp_pkg::*;

  seg_pair_t in_seg;
  div_req_t  req;
  res_word_t word;
  result_t   out_res;
  logic      full;
  logic      en;

  assign en          = !full;
  assign in_ch.ready = en;

  assign in_seg = '{first_start_x:  in_ch.first_start_x,
                    first_start_y:  in_ch.first_start_y,
                    first_end_x:    in_ch.first_end_x,
                    first_end_y:    in_ch.first_end_y,
                    second_start_x: in_ch.second_start_x,
                    second_start_y: in_ch.second_start_y,
                    second_end_x:   in_ch.second_end_x,
                    second_end_y:   in_ch.second_end_y};

  scp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .in_seg   (in_seg),
    .req      (req)
  );

  scp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .req   (req),
    .word  (word)
  );

  scp_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .word      (word),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_res   (out_res),
    .full      (full)
  );

  assign out_ch.pos_on_first  = out_res.pos_on_first;
  assign out_ch.pos_on_second = out_res.pos_on_second;
  assign out_ch.solve_case    = out_res.solve_case;

endmodule

/* hdl/scp_front.sv */
module scp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  scp_pkg::seg_pair_t in_seg,
  output scp_pkg::div_req_t  req
);
  import scp_pkg::*;

  // stage 1: coordinate differences
  logic  s1_valid_r;
  diff_t s1_a_r [4];
  diff_t s1_a_nxt [4];
  diff_t s1_b_r [2];
  diff_t s1_b_nxt [2];
  psum_t s1_pn_r [2];
  psum_t s1_pn_nxt [2];
  logic  s1_degen_r;
  logic  s1_degen_nxt;

  // stage 2: cross products, parallel pivot
  logic  s2_valid_r;
  prod_t s2_prod_r [6];
  prod_t s2_prod_nxt [6];
  psum_t s2_pnum_r;
  psum_t s2_pnum_nxt;
  diff_t s2_pden_r;
  diff_t s2_pden_nxt;
  logic  s2_degen_r;
  logic [DIFF_W-1:0] mag0;
  logic [DIFF_W-1:0] mag1;

  // stage 3: determinant and numerators
  logic  s3_valid_r;
  num_t  s3_det_r;
  num_t  s3_det_nxt;
  num_t  s3_n_r [2];
  num_t  s3_n_nxt [2];
  psum_t s3_pnum_r;
  diff_t s3_pden_r;
  logic  s3_degen_r;

  // stage 4: case selection, sign and magnitude
  div_req_t req_r;
  div_req_t req_nxt;
  logic     par;
  num_t     num0;
  num_t     den0;

  function automatic logic [MAG_W-1:0] mag_of(input num_t v);
    mag_of = v[NUM_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  always_comb begin
    s1_a_nxt[0] = diff_t'(in_seg.first_end_x) - diff_t'(in_seg.first_start_x);
    s1_a_nxt[1] = diff_t'(in_seg.first_end_y) - diff_t'(in_seg.first_start_y);
    s1_a_nxt[2] = diff_t'(in_seg.second_start_x) - diff_t'(in_seg.second_end_x);
    s1_a_nxt[3] = diff_t'(in_seg.second_start_y) - diff_t'(in_seg.second_end_y);
    s1_b_nxt[0] = diff_t'(in_seg.second_start_x) - diff_t'(in_seg.first_start_x);
    s1_b_nxt[1] = diff_t'(in_seg.second_start_y) - diff_t'(in_seg.first_start_y);
    // parallel numerators b0 + a2 and b1 + a3, straight from the coordinates
    s1_pn_nxt[0] = psum_t'(in_seg.second_start_x) + psum_t'(in_seg.second_start_x)
                 - psum_t'(in_seg.first_start_x) - psum_t'(in_seg.second_end_x);
    s1_pn_nxt[1] = psum_t'(in_seg.second_start_y) + psum_t'(in_seg.second_start_y)
                 - psum_t'(in_seg.first_start_y) - psum_t'(in_seg.second_end_y);
    s1_degen_nxt = (in_seg.first_end_x == in_seg.first_start_x) &&
                   (in_seg.first_end_y == in_seg.first_start_y);
  end

  always_comb begin
    s2_prod_nxt[0] = prod_t'(s1_a_r[0]) * prod_t'(s1_a_r[3]);
    s2_prod_nxt[1] = prod_t'(s1_a_r[1]) * prod_t'(s1_a_r[2]);
    s2_prod_nxt[2] = prod_t'(s1_b_r[0]) * prod_t'(s1_a_r[3]);
    s2_prod_nxt[3] = prod_t'(s1_a_r[2]) * prod_t'(s1_b_r[1]);
    s2_prod_nxt[4] = prod_t'(s1_a_r[0]) * prod_t'(s1_b_r[1]);
    s2_prod_nxt[5] = prod_t'(s1_a_r[1]) * prod_t'(s1_b_r[0]);
    mag0 = s1_a_r[0][DIFF_W-1] ? -s1_a_r[0] : s1_a_r[0];
    mag1 = s1_a_r[1][DIFF_W-1] ? -s1_a_r[1] : s1_a_r[1];
    // ties go to the x row
    s2_pnum_nxt = (mag0 >= mag1) ? s1_pn_r[0] : s1_pn_r[1];
    s2_pden_nxt = (mag0 >= mag1) ? s1_a_r[0] : s1_a_r[1];
  end

  always_comb begin
    s3_det_nxt  = num_t'(s2_prod_r[0]) - num_t'(s2_prod_r[1]);
    s3_n_nxt[0] = num_t'(s2_prod_r[2]) - num_t'(s2_prod_r[3]);
    s3_n_nxt[1] = num_t'(s2_prod_r[4]) - num_t'(s2_prod_r[5]);
  end

  always_comb begin
    par = (s3_det_r == '0);
    req_nxt.valid = s3_valid_r;
    if (s3_degen_r) begin
      req_nxt.scase = CASE_DEGEN;
    end else if (par) begin
      req_nxt.scase = CASE_PARALLEL;
    end else begin
      req_nxt.scase = CASE_PROPER;
    end
    num0 = par ? num_t'(s3_pnum_r) : s3_n_r[0];
    den0 = par ? num_t'(s3_pden_r) : s3_det_r;
    req_nxt.arg[0] = '{neg: num0[NUM_W-1] ^ den0[NUM_W-1],
                       num: mag_of(num0), den: mag_of(den0)};
    req_nxt.arg[1] = '{neg: s3_n_r[1][NUM_W-1] ^ s3_det_r[NUM_W-1],
                       num: mag_of(s3_n_r[1]), den: mag_of(s3_det_r)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r     <= s1_a_nxt;
      s1_b_r     <= s1_b_nxt;
      s1_pn_r    <= s1_pn_nxt;
      s1_degen_r <= s1_degen_nxt;
      s2_prod_r  <= s2_prod_nxt;
      s2_pnum_r  <= s2_pnum_nxt;
      s2_pden_r  <= s2_pden_nxt;
      s2_degen_r <= s1_degen_r;
      s3_det_r   <= s3_det_nxt;
      s3_n_r     <= s3_n_nxt;
      s3_pnum_r  <= s2_pnum_r;
      s3_pden_r  <= s2_pden_r;
      s3_degen_r <= s2_degen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.valid <= 1'b0;
    end else if (en) begin
      req_r <= req_nxt;
    end
  end

  assign req = req_r;

endmodule

/* hdl/scp_div.sv */
module scp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  scp_pkg::div_req_t  req,
  output scp_pkg::res_word_t word
);
  import scp_pkg::*;

  prep_t               p1_r;
  prep_t               p1_nxt;
  div_stage_t          st_r [STEPS+1];
  div_stage_t          st0_nxt;
  logic [POS_BITS-1:0] pos [LANES];

  // one restoring step: bring in the next dividend bit, subtract 2*den if it fits
  function automatic lane_st_t step_lane(input lane_st_t s);
    logic [REM_W-1:0] r2;
    lane_st_t         o;
    logic             qbit;
    o    = s;
    r2   = {s.rem, s.sh[POS_BITS-1]};
    qbit = (r2 >= REM_W'(s.d2));
    o.rem = qbit ? D2_W'(r2 - REM_W'(s.d2)) : D2_W'(r2);
    o.sh  = {s.sh[POS_BITS-2:0], qbit};
    return o;
  endfunction

  function automatic div_stage_t step_stage(input div_stage_t s);
    div_stage_t o;
    o = s;
    for (int l = 0; l < LANES; l++) begin
      o.lane[l] = step_lane(s.lane[l]);
    end
    return o;
  endfunction

  function automatic logic [POS_BITS-1:0] finish_lane(input lane_st_t s);
    logic [POS_BITS-1:0] lim;
    logic [POS_BITS-1:0] mag;
    lim = s.neg ? POS_MIN_MAG : POS_MAX_MAG;
    mag = (s.ovf || (s.sh > lim)) ? lim : s.sh;
    return s.neg ? -mag : mag;
  endfunction

  // dividend is 2*num*2^FRAC + den over divisor 2*den: rounds ties away from zero
  always_comb begin
    p1_nxt.valid = req.valid;
    p1_nxt.scase = req.scase;
    for (int l = 0; l < LANES; l++) begin
      p1_nxt.lane[l].x   = (X_W'(req.arg[l].num) << (FRAC_BITS + 1)) + X_W'(req.arg[l].den);
      p1_nxt.lane[l].d2  = {req.arg[l].den, 1'b0};
      p1_nxt.lane[l].neg = req.arg[l].neg;
    end
  end

  // upper dividend bits at or above 2*den mean the quotient needs more than POS_BITS
  always_comb begin
    logic [XP_W-1:0] xp;
    logic [X_W-1:0]  top;
    st0_nxt.valid = p1_r.valid;
    st0_nxt.scase = p1_r.scase;
    for (int l = 0; l < LANES; l++) begin
      xp  = XP_W'(p1_r.lane[l].x);
      top = xp[XP_W-1:POS_BITS];
      st0_nxt.lane[l].ovf = (top >= X_W'(p1_r.lane[l].d2));
      st0_nxt.lane[l].rem = D2_W'(top);
      st0_nxt.lane[l].sh  = xp[POS_BITS-1:0];
      st0_nxt.lane[l].d2  = p1_r.lane[l].d2;
      st0_nxt.lane[l].neg = p1_r.lane[l].neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r.valid    <= 1'b0;
      st_r[0].valid <= 1'b0;
    end else if (en) begin
      p1_r    <= p1_nxt;
      st_r[0] <= st0_nxt;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k+1].valid <= 1'b0;
      end else if (en) begin
        st_r[k+1] <= step_stage(st_r[k]);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      pos[l] = finish_lane(st_r[STEPS].lane[l]);
    end
    word.valid          = st_r[STEPS].valid;
    word.res.solve_case = st_r[STEPS].scase;
    case (st_r[STEPS].scase)
      CASE_DEGEN: begin
        word.res.pos_on_first  = POS_HALF;
        word.res.pos_on_second = POS_HALF;
      end
      CASE_PARALLEL: begin
        word.res.pos_on_first  = pos[0];
        word.res.pos_on_second = POS_MINUS_ONE;
      end
      default: begin
        word.res.pos_on_first  = pos[0];
        word.res.pos_on_second = pos[1];
      end
    endcase
  end

endmodule

/* hdl/scp_skid.sv */
module scp_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  scp_pkg::res_word_t word,
  input  logic               out_ready,
  output logic               out_valid,
  output scp_pkg::result_t   out_res,
  output logic               full
);
  import scp_pkg::*;

  result_t            ent_r [SKID_DEPTH];
  logic [SKID_AW-1:0] wr_ptr_r;
  logic [SKID_AW-1:0] rd_ptr_r;
  logic [SKID_CW-1:0] cnt_r;
  logic               do_push;
  logic               do_pop;

  // full comes from the count alone, so out_ready never reaches in_ready
  assign full      = (cnt_r == SKID_CW'(SKID_DEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_res   = ent_r[rd_ptr_r];
  assign do_push   = word.valid && !full;
  assign do_pop    = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + SKID_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + SKID_AW'(1);
      end
      cnt_r <= cnt_r + SKID_CW'(do_push) - SKID_CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= word.res;
    end
  end

endmodule

/* hdl/scp_chk.sv */
`include "assert_macros.svh"

module scp_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [scp_pkg::POS_BITS-1:0] out_pos_on_first,
  input logic signed [scp_pkg::POS_BITS-1:0] out_pos_on_second,
  input logic [scp_pkg::CASE_BITS-1:0]       out_solve_case
);
  import scp_pkg::*;

  // an empty output buffer never back-pressures the input
  `SCP_ASSERT_IMP(a_idle_ready, !out_valid, in_ready, "input stalled with no word pending")

  `SCP_ASSERT_IMP(a_degen_half, out_valid && out_solve_case == CASE_DEGEN, out_pos_on_first == POS_HALF && out_pos_on_second == POS_HALF, "degenerate word without half positions")

  `SCP_ASSERT_IMP(a_par_minus, out_valid && out_solve_case == CASE_PARALLEL, out_pos_on_second == POS_MINUS_ONE, "parallel word without minus one on second")

  `SCP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pos_on_first) && $stable(out_pos_on_second) && $stable(out_solve_case), "stalled output word changed")

endmodule

bind segment_crossing_parameters_core scp_chk u_scp_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_pos_on_first  (out_ch.pos_on_first),
  .out_pos_on_second (out_ch.pos_on_second),
  .out_solve_case    (out_ch.solve_case)
);
